// ===== src/ttmc_pkg.sv =====
// shared constants and types for the top-two margin confidence block
`timescale 1ns / 1ps
`default_nettype none

package ttmc_pkg;

  // logit format: signed, half of the bits are fraction
  localparam int LOGIT_WIDTH = 16;
  localparam int FRAC_BITS   = LOGIT_WIDTH / 2;
  localparam int IDX_SHIFT   = FRAC_BITS - 4;
  localparam int S_DATA_W    = ((LOGIT_WIDTH + 7) / 8) * 8;

  // confidence table
  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int CONF_W      = 16;
  localparam logic [CONF_W-1:0] FULL_SCALE = {CONF_W{1'b1}};

  // exp(-1/16) in Q0.32
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [LOGIT_WIDTH-1:0] logit_t;

  // finished vector handed from front to back
  typedef struct packed {
    logit_t best;
    logit_t second;
    logic   have_second;
  } vec_result_t;

  // table write port
  typedef struct packed {
    logic                en;
    logic [TBL_AW-1:0]   addr;
    logic [CONF_W-1:0]   data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== src/ttmc_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ttmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ttmc_table_gen.sv =====
// builds the sigmoid confidence table after reset, one entry per pass
`timescale 1ns / 1ps
`default_nettype none

module ttmc_table_gen (
  input  wire logic             clk,
  input  wire logic             rst,
  output ttmc_pkg::tbl_wr_t     tbl_wr,
  output logic                  table_ready
);
  import ttmc_pkg::*;

  typedef enum logic [2:0] {
    S_START,
    S_DIV,
    S_WRITE,
    S_EXP,
    S_DONE
  } state_t;

  localparam logic [48:0] TWO_48   = 49'h1_0000_0000_0000;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [64:0] HALF_Q32 = 65'h8000_0000;

  state_t            state;
  logic [TBL_AW-1:0] idx;
  logic [32:0]       e_val;     // exp(-idx/16) in Q1.32
  logic [64:0]       prod;
  logic [33:0]       divisor;
  logic [33:0]       rem;
  logic [16:0]       num_lo;
  logic [16:0]       quot;
  logic [4:0]        bit_cnt;

  logic [33:0] d_val;
  logic [48:0] num_val;
  logic [34:0] div_shift;
  logic        div_ge;
  logic [64:0] exp_sum;

  // divisor, rounded numerator, one restoring divide step, exp update
  always_comb begin
    d_val     = {1'b0, ONE_Q32} + {1'b0, e_val};
    num_val   = TWO_48 + 49'(d_val >> 1);
    div_shift = {rem, num_lo[16]};
    div_ge    = div_shift >= {1'b0, divisor};
    exp_sum   = prod + HALF_Q32;
  end

  // sequencer: divide, write entry, step the exponential
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_wr.en   <= 1'b0;
      state       <= S_START;
      idx         <= '0;
      e_val       <= ONE_Q32;
      table_ready <= 1'b0;
    end else begin
      tbl_wr.en <= (state == S_WRITE);
      unique case (state)
        S_START: begin
          divisor <= d_val;
          rem     <= {2'b00, num_val[48:17]};
          num_lo  <= num_val[16:0];
          quot    <= '0;
          bit_cnt <= 5'd16;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= div_ge ? 34'(div_shift - {1'b0, divisor}) : div_shift[33:0];
          quot    <= {quot[15:0], div_ge};
          num_lo  <= {num_lo[15:0], 1'b0};
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          tbl_wr.addr <= idx;
          tbl_wr.data <= quot[16] ? FULL_SCALE : quot[CONF_W-1:0];
          prod        <= 65'(e_val * EXP_STEP_Q32);
          if (idx == TBL_AW'(TABLE_DEPTH - 1)) begin
            state <= S_DONE;
          end else begin
            state <= S_EXP;
          end
        end
        S_EXP: begin
          e_val <= exp_sum[64:32];
          idx   <= idx + TBL_AW'(1);
          state <= S_START;
        end
        S_DONE: begin
          table_ready <= 1'b1;
        end
        default: state <= S_START;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ttmc_front.sv =====
// input side: accepts logits and tracks the top two values of a vector
`timescale 1ns / 1ps
`default_nettype none

module ttmc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ttmc_pkg::S_DATA_W-1:0] s_axis_tdata,  // logit
  input  wire logic                          s_axis_tlast,  // last
  input  wire logic                          table_ready,
  input  wire logic                          q_full,
  output logic                               q_push,
  output ttmc_pkg::vec_result_t              q_wdata
);
  import ttmc_pkg::*;

  logit_t best, best_next;
  logit_t second, second_next;
  logic   have_second, have_second_next;
  logic   at_start;

  logit_t v;
  logic   accept;

  assign s_axis_tready = table_ready && !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign v             = logit_t'(s_axis_tdata[LOGIT_WIDTH-1:0]);

  // top-two update, strict compare for the top slot
  always_comb begin
    best_next        = best;
    second_next      = second;
    have_second_next = have_second;
    if (accept) begin
      priority if (at_start) begin
        best_next        = v;
        second_next      = v;
        have_second_next = 1'b0;
      end else if (v > best) begin
        second_next      = best;
        best_next        = v;
        have_second_next = 1'b1;
      end else if (!have_second || v > second) begin
        second_next      = v;
        have_second_next = 1'b1;
      end else begin
        // at or below both slots: nothing changes
      end
    end
  end

  // finished vector goes to the queue
  assign q_push              = accept && s_axis_tlast;
  assign q_wdata.best        = best_next;
  assign q_wdata.second      = second_next;
  assign q_wdata.have_second = have_second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      best        <= '0;
      second      <= '0;
      have_second <= 1'b0;
      at_start    <= 1'b1;
    end else begin
      best        <= best_next;
      second      <= second_next;
      have_second <= have_second_next;
      if (accept) begin
        at_start <= s_axis_tlast;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ttmc_queue.sv =====
// short queue of finished vectors between front and back
`timescale 1ns / 1ps
`default_nettype none

module ttmc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ttmc_pkg::vec_result_t wdata,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       valid,
  output ttmc_pkg::vec_result_t      head
);
  import ttmc_pkg::*;

  vec_result_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ttmc_back.sv =====
// output side: margin to table index, table read, output buffer
`timescale 1ns / 1ps
`default_nettype none

module ttmc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire ttmc_pkg::vec_result_t       q_head,
  output logic                             q_pop,
  output logic [ttmc_pkg::TBL_AW-1:0]      tbl_raddr,
  input  wire logic [ttmc_pkg::CONF_W-1:0] tbl_rdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [ttmc_pkg::CONF_W-1:0]      m_axis_tdata   // confidence
);
  import ttmc_pkg::*;

  logic [LOGIT_WIDTH-1:0] margin;
  logic [LOGIT_WIDTH-1:0] idx_raw;

  logic        rd_valid;      // table read in flight
  logic        rd_single;     // vector had one element
  logic [CONF_W-1:0] out_mem [2];
  logic        out_wr_ptr;
  logic        out_rd_ptr;
  logic [1:0]  out_count;
  logic        drain;
  logic [2:0]  occ_after;

  // saturated table index from the top-two margin
  always_comb begin
    margin  = LOGIT_WIDTH'(q_head.best - q_head.second);
    idx_raw = margin >> IDX_SHIFT;
    if (32'(idx_raw) > 32'(TABLE_DEPTH - 1)) begin
      tbl_raddr = TBL_AW'(TABLE_DEPTH - 1);
    end else begin
      tbl_raddr = TBL_AW'(idx_raw);
    end
  end

  // pop only if the word will find room when its read data lands
  assign m_axis_tvalid = out_count != 2'd0;
  assign m_axis_tdata  = out_mem[out_rd_ptr];
  assign drain         = m_axis_tvalid && m_axis_tready;
  assign occ_after     = {1'b0, out_count} + {2'b00, rd_valid} - {2'b00, drain};
  assign q_pop         = q_valid && (occ_after <= 3'd1);

  // output buffer storage
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      out_mem[out_wr_ptr] <= rd_single ? FULL_SCALE : tbl_rdata;
    end
    if (q_pop) begin
      rd_single <= !q_head.have_second;
    end
  end

  // read tracking and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= 2'd0;
    end else begin
      rd_valid <= q_pop;
      if (rd_valid) begin
        out_wr_ptr <= !out_wr_ptr;
      end
      if (drain) begin
        out_rd_ptr <= !out_rd_ptr;
      end
      unique case ({rd_valid, drain})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/top_two_margin_confidence.sv =====
// top level: top-two logit margin to sigmoid confidence, streaming
// a result passes from the vector queue through the registered table read into the output buffer
// throughput: one word per cycle while the vector queue is not full, one result per vector, no bubbles between vectors
// the output buffer holds two results, so input keeps flowing while output stalls until the queue is full
// after reset the table builder fills the 256-entry table one entry at a time, and
// s_axis_tready stays low until the table is complete
`timescale 1ns / 1ps
`default_nettype none

module top_two_margin_confidence (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ttmc_pkg::S_DATA_W-1:0] s_axis_tdata,  // logit
  input  wire logic                          s_axis_tlast,  // last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ttmc_pkg::CONF_W-1:0]        m_axis_tdata   // confidence
);
  import ttmc_pkg::*;

  tbl_wr_t           tbl_wr;
  logic              table_ready;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [CONF_W-1:0] tbl_rdata;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  vec_result_t q_wdata;
  vec_result_t q_head;

  // table builder and table memory
  ttmc_table_gen u_table_gen (
    .clk         (clk),
    .rst         (rst),
    .tbl_wr      (tbl_wr),
    .table_ready (table_ready)
  );

  ttmc_ram #(
    .WIDTH (CONF_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // front: top-two tracking
  ttmc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .table_ready   (table_ready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // queue of finished vectors
  ttmc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .head  (q_head)
  );

  // back: table lookup and output
  ttmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .tbl_raddr     (tbl_raddr),
    .tbl_rdata     (tbl_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // no word is taken before the table is complete
  a_no_accept_during_build: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> table_ready)
    else $error("word accepted while table is being built");

  // the table is never written once it is declared ready
  a_no_write_after_ready: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> !table_ready)
    else $error("table written after build finished");

  // the queue is never pushed while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("vector queue overflow");

  // confidence is always at least one half
  a_conf_at_least_half: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[CONF_W-1])
    else $error("confidence below one half");

endmodule

`default_nettype wire
